// File: hdl/lsr_pkg.sv
// Package for the linear set-point ramp: widths, reset values, sequencer states and divider control.
package lsr_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int RAMP_TICKS_RESET    = 100;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_ADD,
      ST_OUT
   } seq_state_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// File: hdl/lsr_divider.sv
// Restoring unsigned divider for the ramp: one quotient bit per cycle through one subtractor.
module lsr_divider #(
   parameter int QUO_WIDTH = 33,
   parameter int DIV_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lsr_pkg::div_ctrl_type          ctrl,
   output lsr_pkg::div_stat_type          stat,
   input  logic [QUO_WIDTH+DIV_WIDTH-1:0] dividend,
   input  logic [DIV_WIDTH-1:0]           divisor,
   output logic [QUO_WIDTH-1:0]           quotient
);
   import lsr_pkg::*;

   localparam int STEP_WIDTH = $clog2(QUO_WIDTH + 1);

   logic [DIV_WIDTH-1:0]  rem_ff, rem_in;
   logic [QUO_WIDTH-1:0]  quo_ff, quo_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_WIDTH:0]    trial;
   logic                  fits;

   // Shift the next dividend bit into the partial remainder and try the subtract.
   assign trial = {rem_ff, quo_ff[QUO_WIDTH-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         // Upper part is already below the divisor since the quotient fits QUO_WIDTH bits.
         rem_in  = dividend[QUO_WIDTH+DIV_WIDTH-1:QUO_WIDTH];
         quo_in  = dividend[QUO_WIDTH-1:0];
         step_in = STEP_WIDTH'(QUO_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? DIV_WIDTH'(trial - {1'b0, divisor}) : trial[DIV_WIDTH-1:0];
         quo_in  = {quo_ff[QUO_WIDTH-2:0], fits};
         step_in = step_ff - STEP_WIDTH'(1);
         if (step_ff == STEP_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

// File: hdl/linear_setpoint_ramp_core.sv
// Top level of the linear set-point ramp generator: tick handling, sequencer and output register.
//
// Each accepted tick carries a signed Q16.16 target. A change of target restarts the ramp from
// the last output; the tick counter advances and saturates at ramp_ticks, and the result is
// start + (target - start) * count / ramp_ticks, truncated toward zero, or the target itself
// with ramp_done raised once the count reaches ramp_ticks. One tick is worked at a time and
// req_stall is high until its result has been transferred. A ramping tick passes through the
// states EVAL, MUL, DIV_START, DIV_WAIT, ADD and OUT: the VALUE_WIDTH + 1 quotient bits are
// formed one per cycle by the restoring divider, after a registered magnitude multiply. A tick
// that holds or finishes the ramp passes from EVAL straight to OUT. A result waits in OUT
// while rsp_stall is high. ramp_ticks is written over the csr_ channel, always ready, and
// must only be written while no tick is in flight.
module linear_setpoint_ramp_core #(
   parameter int VALUE_WIDTH = lsr_pkg::VALUE_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = lsr_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_target_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VALUE_WIDTH-1:0] rsp_set_point,
   output logic                          rsp_ramp_done,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [COUNT_WIDTH-1:0]        csr_ramp_ticks
);
   import lsr_pkg::*;

   // Difference of two values needs one extra bit; the product adds the count width.
   localparam int DIFF_WIDTH = VALUE_WIDTH + 1;
   localparam int PROD_WIDTH = DIFF_WIDTH + COUNT_WIDTH;

   seq_state_type state_ff, state_in;

   // Ramp state.
   logic [COUNT_WIDTH-1:0] ramp_ticks_ff;
   logic [VALUE_WIDTH-1:0] start_ff, start_in;
   logic [VALUE_WIDTH-1:0] held_ff, held_in;
   logic [VALUE_WIDTH-1:0] last_ff, last_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   done_ff, done_in;

   // Datapath registers.
   logic [DIFF_WIDTH-1:0]  mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [PROD_WIDTH-1:0]  prod_ff, prod_in;
   logic [VALUE_WIDTH-1:0] result_ff, result_in;

   // Tick-entry values.
   logic                   tgt_changed;
   logic [COUNT_WIDTH-1:0] count_base;
   logic [DIFF_WIDTH-1:0]  diff;
   logic [VALUE_WIDTH-1:0] q_low;
   logic [VALUE_WIDTH-1:0] q_signed;

   div_ctrl_type           div_ctrl;
   div_stat_type           div_stat;
   logic [DIFF_WIDTH-1:0]  div_quotient;

   logic                   req_xfer;
   logic                   rsp_xfer;

   assign req_xfer  = req_valid && (state_ff == ST_IDLE);
   assign rsp_xfer  = (state_ff == ST_OUT) && !rsp_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = state_ff == ST_OUT;
   assign csr_ready = 1'b1;

   assign tgt_changed = VALUE_WIDTH'(req_target_value) != held_ff;
   assign count_base  = tgt_changed ? '0 : count_ff;

   assign diff = {held_ff[VALUE_WIDTH-1], held_ff} - {start_ff[VALUE_WIDTH-1], start_ff};

   // Quotient magnitude stays below 2**VALUE_WIDTH, so the low bits carry it modulo the width.
   assign q_low    = div_quotient[VALUE_WIDTH-1:0];
   assign q_signed = neg_ff ? (~q_low + VALUE_WIDTH'(1)) : q_low;

   always_comb begin
      state_in       = state_ff;
      start_in       = start_ff;
      held_in        = held_ff;
      last_in        = last_ff;
      count_in       = count_ff;
      done_in        = done_ff;
      mag_in         = mag_ff;
      neg_in         = neg_ff;
      prod_in        = prod_ff;
      result_in      = result_ff;
      div_ctrl.start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               // Restart the ramp on a new target, then advance the saturating counter.
               if (tgt_changed) begin
                  done_in  = 1'b0;
                  start_in = last_ff;
               end
               held_in  = VALUE_WIDTH'(req_target_value);
               count_in = (count_base < ramp_ticks_ff) ? count_base + COUNT_WIDTH'(1)
                                                       : count_base;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (count_ff >= ramp_ticks_ff) begin
               // Finish: lock onto the target.
               done_in   = 1'b1;
               start_in  = held_ff;
               last_in   = held_ff;
               result_in = held_ff;
               state_in  = ST_OUT;
            end else if ((start_ff != held_ff) && !done_ff) begin
               neg_in   = diff[DIFF_WIDTH-1];
               mag_in   = diff[DIFF_WIDTH-1] ? (~diff + DIFF_WIDTH'(1)) : diff;
               state_in = ST_MUL;
            end else begin
               // Hold the start value.
               result_in = start_ff;
               state_in  = ST_OUT;
            end
         end
         ST_MUL: begin
            prod_in  = {{COUNT_WIDTH{1'b0}}, mag_ff} * {{DIFF_WIDTH{1'b0}}, count_ff};
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            div_ctrl.start = 1'b1;
            state_in       = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            result_in = start_ff + q_signed;
            last_in   = start_ff + q_signed;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_xfer) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ramp_ticks_ff <= COUNT_WIDTH'(RAMP_TICKS_RESET);
         start_ff      <= '0;
         held_ff       <= '0;
         last_ff       <= '0;
         count_ff      <= '0;
         done_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            ramp_ticks_ff <= csr_ramp_ticks;
         end
         start_ff <= start_in;
         held_ff  <= held_in;
         last_ff  <= last_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      prod_ff   <= prod_in;
      result_ff <= result_in;
   end

   lsr_divider #(
      .QUO_WIDTH (DIFF_WIDTH),
      .DIV_WIDTH (COUNT_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .stat     (div_stat),
      .dividend (prod_ff),
      .divisor  (ramp_ticks_ff),
      .quotient (div_quotient)
   );

   assign rsp_set_point = result_ff;
   assign rsp_ramp_done = done_ff;

endmodule

// File: bench/linear_setpoint_ramp_core_tb.sv
// Self-checking testbench for the linear set-point ramp core: planned ticks, ramp prediction, checks.
`timescale 1ns / 100ps

module linear_setpoint_ramp_core_tb;

   import lsr_pkg::*;

   localparam int VW = VALUE_WIDTH_DEFAULT;
   localparam int CW = COUNT_WIDTH_DEFAULT;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 8;
   localparam int TOTAL_TICKS  = 1220;     // directed plus random ticks
   localparam int CSR_QUIET    = 4;        // idle cycles before a ramp_ticks write
   localparam int END_SETTLE   = 60;       // a little over one ramping tick
   localparam int HOLD_AT      = 400;      // results seen before the long hold-off
   localparam int HOLD_LEN     = 500;      // cycles of the long hold-off
   localparam int CYCLE_LIMIT  = 600000;

   // Kinds of entry in the stimulus plan.
   typedef enum logic [1:0] {
      PLAN_TICK,     // offer one tick carrying a target
      PLAN_CSR,      // write ramp_ticks once the core is quiet
      PLAN_DRAIN     // hold off until every expected result is back
   } plan_kind_type;

   typedef struct {
      plan_kind_type kind;
      logic [31:0]   value;
      int unsigned   gap;
   } plan_step_type;

   typedef struct {
      logic signed [VW-1:0] set_point;
      logic                 ramp_done;
   } ramp_point_type;

   // Clock, reset and the core's inputs, all known from time zero.
   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic signed [VW-1:0] req_target_value = '0;
   logic                 rsp_stall        = 1'b0;
   logic                 csr_valid        = 1'b0;
   logic [CW-1:0]        csr_ramp_ticks   = '0;

   logic                 req_stall;
   logic                 rsp_valid;
   logic signed [VW-1:0] rsp_set_point;
   logic                 rsp_ramp_done;
   logic                 csr_ready;

   // Stimulus plan and the results it is expected to produce, oldest first.
   plan_step_type  tick_plan[$];
   ramp_point_type expected_points[$];
   int unsigned    planned_ticks = 0;

   // Mirror of the ramp state and of the ramp_ticks register.
   logic signed [VW-1:0] mirror_start  = '0;
   logic signed [VW-1:0] mirror_held   = '0;
   logic signed [VW-1:0] mirror_last   = '0;
   logic [CW-1:0]        mirror_count  = '0;
   logic                 mirror_done   = 1'b0;
   logic [CW-1:0]        mirror_length = CW'(RAMP_TICKS_RESET);

   // Transfers seen at the last rising edge, read by the falling-edge drivers.
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic csr_fire = 1'b0;

   int unsigned cycle_count  = 0;
   int unsigned result_count = 0;
   int unsigned error_count  = 0;
   int unsigned gap_cycles   = 0;
   int unsigned quiet_cycles = 0;
   int unsigned stall_budget = 0;
   int unsigned hold_left    = 0;
   logic        hold_started = 1'b0;

   linear_setpoint_ramp_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_target_value (req_target_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_set_point    (rsp_set_point),
      .rsp_ramp_done    (rsp_ramp_done),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_ramp_ticks   (csr_ramp_ticks)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // Advance the mirrored ramp by one tick and return the set-point it should produce.
   function automatic ramp_point_type ramp_advance(input logic signed [VW-1:0] target);
      ramp_point_type point;
      longint         base;
      longint         delta;
      longint         scaled;
      // A new target restarts the ramp from wherever the output last stood.
      if (target != mirror_held) begin
         mirror_count = '0;
         mirror_done  = 1'b0;
         mirror_start = mirror_last;
      end
      mirror_held = target;
      // Saturate the tick counter at the ramp length.
      if (mirror_count < mirror_length)
         mirror_count = mirror_count + 1'b1;
      if (mirror_count >= mirror_length) begin
         mirror_done     = 1'b1;
         mirror_start    = target;
         mirror_last     = target;
         point.set_point = target;
      end else if (mirror_start != target && !mirror_done) begin
         // Form the full product first, then divide with truncation toward zero.
         base            = mirror_start;
         delta           = longint'(target) - base;
         scaled          = (delta * longint'(mirror_count)) / longint'(mirror_length);
         point.set_point = base + scaled;
         mirror_last     = point.set_point;
      end else begin
         // Target equals the start value, or the ramp is done: hold the start.
         point.set_point = mirror_start;
      end
      point.ramp_done = mirror_done;
      return point;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
   endtask

   task automatic plan_tick(input logic [31:0] target, input int unsigned gap);
      plan_step_type step;
      step.kind  = PLAN_TICK;
      step.value = target;
      step.gap   = gap;
      tick_plan.push_back(step);
      planned_ticks++;
   endtask

   task automatic plan_ramp(input logic [31:0] target, input int unsigned count, input bit burst);
      repeat (count) plan_tick(target, burst ? 0 : $urandom_range(0, 8));
   endtask

   task automatic plan_csr(input logic [CW-1:0] length);
      plan_step_type step;
      step.kind  = PLAN_CSR;
      step.value = 32'(length);
      step.gap   = 0;
      tick_plan.push_back(step);
   endtask

   function automatic logic [CW-1:0] pick_length();
      case ($urandom_range(0, 9))
         0:       return CW'(1);
         1:       return {CW{1'b1}};
         2:       return CW'($urandom_range(21, 400));
         default: return CW'($urandom_range(2, 20));
      endcase
   endfunction

   function automatic logic [31:0] pick_target(input logic [31:0] prev);
      case ($urandom_range(0, 5))
         1:       return 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
         2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         3:       return prev + 32'($urandom_range(0, 2)) - 32'd1;
         default: return $urandom;
      endcase
   endfunction

   // Monitor: sample every transfer at the rising edge, predict on each accepted tick and
   // check each result against the oldest prediction.
   always @(posedge clock) begin : monitor
      ramp_point_type want;
      cycle_count++;
      req_fire = 1'b0;
      rsp_fire = 1'b0;
      csr_fire = 1'b0;
      if (!reset) begin
         // Check the result first so a stray result never consumes a prediction made here.
         if (rsp_valid && !rsp_stall) begin
            rsp_fire = 1'b1;
            result_count++;
            if (expected_points.size() == 0) begin
               report_mismatch($sformatf("result with none expected: set_point=%h done=%b",
                                         rsp_set_point, rsp_ramp_done));
            end else begin
               want = expected_points.pop_front();
               if (rsp_set_point !== want.set_point)
                  report_mismatch($sformatf("set_point %h, expected %h",
                                            rsp_set_point, want.set_point));
               if (rsp_ramp_done !== want.ramp_done)
                  report_mismatch($sformatf("ramp_done %b, expected %b",
                                            rsp_ramp_done, want.ramp_done));
            end
         end
         if (csr_valid && csr_ready) begin
            csr_fire      = 1'b1;
            mirror_length = csr_ramp_ticks;
         end
         if (req_valid && !req_stall) begin
            req_fire = 1'b1;
            expected_points.push_back(ramp_advance(req_target_value));
         end
      end
   end

   // Driver: work the plan at the falling edge. Hold a tick until its transfer, wait out the
   // gap drawn for the next one, and write ramp_ticks only once the core has gone quiet.
   always @(negedge clock) begin : driver
      logic          tick_up;
      logic          csr_up;
      plan_step_type head;
      tick_up = req_valid;
      csr_up  = csr_valid;
      if (!reset) begin
         if (req_fire)
            tick_up = 1'b0;
         if (csr_fire)
            csr_up = 1'b0;
         // Count cycles with nothing in flight and nothing offered.
         if (expected_points.size() == 0 && !tick_up)
            quiet_cycles++;
         else
            quiet_cycles = 0;
         if (!tick_up && !csr_up && tick_plan.size() != 0) begin
            head = tick_plan[0];
            case (head.kind)
               PLAN_TICK: begin
                  if (gap_cycles >= head.gap) begin
                     tick_up          = 1'b1;
                     req_target_value <= head.value;
                     gap_cycles       = 0;
                     void'(tick_plan.pop_front());
                  end else begin
                     gap_cycles++;
                  end
               end
               PLAN_CSR: begin
                  if (quiet_cycles >= CSR_QUIET) begin
                     csr_up         = 1'b1;
                     csr_ramp_ticks <= head.value[CW-1:0];
                     void'(tick_plan.pop_front());
                  end
               end
               PLAN_DRAIN: begin
                  if (quiet_cycles >= 1)
                     void'(tick_plan.pop_front());
               end
               default: void'(tick_plan.pop_front());
            endcase
         end
      end
      req_valid <= tick_up;
      csr_valid <= csr_up;
   end

   // Long hold-off: once enough results have come, stall the result side for a long stretch
   // while the plan keeps offering ticks, so the core backs up and stalls its input.
   always @(negedge clock) begin : long_hold
      if (!reset && !hold_started && result_count >= HOLD_AT) begin
         hold_started <= 1'b1;
         hold_left    <= HOLD_LEN;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Receiver: draw a stall for each result after the previous transfer; spend it only while a
   // result is offered. Every fourth stretch of 64 results runs without stalls.
   always @(negedge clock) begin : receiver
      if (rsp_fire)
         stall_budget = ((result_count / 64) % 4 == 1) ? 0 : $urandom_range(0, 8);
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
      end else if (rsp_valid && stall_budget != 0) begin
         rsp_stall <= 1'b1;
         stall_budget--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Timeout guard.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : sequencer
      logic [CW-1:0] length;
      logic [31:0]   target;
      int unsigned   ramps;
      int unsigned   span;
      int unsigned   reps;
      int unsigned   phase;
      bit            burst;

      // Directed: reset length of 100 first. A target equal to the held one keeps the start.
      plan_tick(32'h0000_0000, 0);
      plan_ramp(32'h0064_0000, 2, 0);
      // The last output (2.0) becomes the start, and the new target equals it: hold it.
      plan_ramp(32'h0002_0000, 2, 0);
      // Short ramps between the extremes of the field, finishing and saturating.
      plan_csr(CW'(4));
      plan_ramp(32'h7FFF_FFFF, 3, 0);
      plan_ramp(32'h8000_0000, 4, 0);
      plan_ramp(32'hFFFF_FFFF, 1, 0);
      // Length of one: every tick lands on its target.
      plan_csr(CW'(1));
      plan_ramp(32'h1234_5678, 1, 0);
      plan_ramp(32'hEDCB_A987, 2, 0);
      // Longest ramp, then shorten it below the count: the ramp finishes on the next tick.
      plan_csr({CW{1'b1}});
      plan_ramp(32'h7FFF_FFFF, 2, 0);
      plan_ramp(32'h8000_0000, 3, 0);
      plan_csr(CW'(2));
      plan_ramp(32'h8000_0000, 1, 0);

      // Random phases: mostly held targets long enough to reach or near the end of a ramp,
      // with single-tick noise mixed in.
      target = '0;
      phase  = 0;
      while (planned_ticks < TOTAL_TICKS) begin
         length = pick_length();
         plan_csr(length);
         burst = ($urandom_range(0, 3) == 0);
         ramps = $urandom_range(3, 10);
         for (int r = 0; r < ramps; r++) begin
            target = pick_target(target);
            if ($urandom_range(0, 9) < 7) begin
               span = (length > 37) ? 40 : length + 3;
               reps = $urandom_range(1, span);
            end else begin
               reps = 1;
            end
            plan_ramp(target, reps, burst);
         end
         // Pause the sender once mid-run until the core has drained.
         if (phase == 6)
            tick_plan.push_back('{kind: PLAN_DRAIN, value: 32'd0, gap: 0});
         phase++;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for the plan to empty and every prediction to be matched, then let it settle.
      while (tick_plan.size() != 0 || req_valid || csr_valid || expected_points.size() != 0)
         @(posedge clock);
      repeat (END_SETTLE) @(posedge clock);

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
